// ===== hdl/clw_pkg.sv =====
package clw_pkg;

  localparam int unsigned WindowDefault = 16;
  localparam int unsigned NodesDefault  = 8;
  localparam int unsigned MaxOut        = 16;
  localparam logic [3:0]  NumNodesReset = 4'd3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_VOTE   = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic exec;      // apply insert or vote
    logic find_init; // clamp free pointer
    logic find_step; // advance free pointer
    logic scan_step; // count one more confirmable slot
    logic confirm;   // free head entry, advance start, load confirmed word
    logic emit_last; // load output register (final, no confirmation)
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_find;
    logic       find_more;
    logic       scan_more;
    logic       conf_left;
    logic       conf_last;
  } stat_t;

endpackage

// ===== hdl/consensus_log_window.sv =====
// Windowed consensus log.
// Input channel: in_valid_i / in_stall_o with one port per field; a word is
// taken at a rising edge with valid high and stall low. Output channel:
// out_valid_o / out_stall_i; each result word is held stable while stalled.
// num_nodes is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while the block is idle, as the block itself does not enforce it.
// Each input gives one result word, or one per confirmed slot (at most 16).
// Insert, vote or unknown op steps through exec, check and emit; find empty
// adds a find state that walks the filled slots. Confirmable slots are
// counted first, so every word carries the final window start; each later
// word waits, as the single output register must empty before the next word
// is loaded. Stall stays high from the input edge until the last word of
// that input is in the output register, so no new input is taken before that.
// Reset clears all filled marks and pointers and sets num_nodes to 3.
// A stalled receiver holds the output word and stops further words.
module consensus_log_window #(
  parameter int unsigned WINDOW = clw_pkg::WindowDefault,
  parameter int unsigned NODES  = clw_pkg::NodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] slot_number_i,
  input  logic [31:0] entry_value_i,
  input  logic [7:0]  vote_mask_i,
  input  logic [31:0] ballot_number_i,
  input  logic [2:0]  voter_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [31:0] found_slot_o,
  output logic [31:0] window_start_o,
  output logic [31:0] highest_slot_o,
  output logic        confirmed_valid_o,
  output logic [31:0] confirmed_slot_o,
  output logic [31:0] confirmed_value_o,
  output logic        last_result_o
);
  import clw_pkg::*;

  logic [3:0] num_nodes_q;
  cmd_t       cmd;
  stat_t      stat;
  logic       busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_nodes_q <= NumNodesReset;
    else if (cfg_we_i) num_nodes_q <= cfg_wdata_i;
  end

  clw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(busy), .stat_i(stat), .cmd_o(cmd)
  );

  clw_dp #(.WINDOW(WINDOW), .NODES(NODES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .num_nodes_i(num_nodes_q),
    .operation_i, .slot_number_i, .entry_value_i, .vote_mask_i,
    .ballot_number_i, .voter_id_i, .out_busy_o(busy), .out_valid_o, .out_stall_i,
    .accepted_o, .found_slot_o, .window_start_o, .highest_slot_o,
    .confirmed_valid_o, .confirmed_slot_o, .confirmed_value_o, .last_result_o
  );

endmodule

// ===== hdl/clw_ctrl.sv =====
module clw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_busy_i,
  input  clw_pkg::stat_t  stat_i,
  output clw_pkg::cmd_t   cmd_o
);
  import clw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_find) begin
          cmd_o.find_init = 1'b1;
          state_d         = ST_FIND;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_FIND: begin
        if (stat_i.find_more) cmd_o.find_step = 1'b1;
        else state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // count the run of confirmable slots before any word leaves
        if (stat_i.scan_more) cmd_o.scan_step = 1'b1;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the previous word has left the output register
        if (!out_busy_i) begin
          if (stat_i.conf_left) begin
            cmd_o.confirm = 1'b1;
            if (stat_i.conf_last) state_d = ST_IDLE;
          end else begin
            cmd_o.emit_last = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/clw_dp.sv =====
module clw_dp #(
  parameter int unsigned WINDOW = clw_pkg::WindowDefault,
  parameter int unsigned NODES  = clw_pkg::NodesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clw_pkg::cmd_t  cmd_i,
  output clw_pkg::stat_t stat_o,
  input  logic [3:0]     num_nodes_i,
  input  logic [1:0]     operation_i,
  input  logic [31:0]    slot_number_i,
  input  logic [31:0]    entry_value_i,
  input  logic [7:0]     vote_mask_i,
  input  logic [31:0]    ballot_number_i,
  input  logic [2:0]     voter_id_i,
  output logic           out_busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           accepted_o,
  output logic [31:0]    found_slot_o,
  output logic [31:0]    window_start_o,
  output logic [31:0]    highest_slot_o,
  output logic           confirmed_valid_o,
  output logic [31:0]    confirmed_slot_o,
  output logic [31:0]    confirmed_value_o,
  output logic           last_result_o
);
  import clw_pkg::*;

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW = IdxW + 1;
  localparam int unsigned StW  = $clog2(WINDOW + 1);
  localparam int unsigned PcW  = 4;
  localparam int unsigned ScanMax = (MaxOut < WINDOW) ? MaxOut : WINDOW;
  localparam logic [7:0]  NodeMask = (NODES >= 8) ? 8'hFF : 8'((1 << NODES) - 1);

  logic [31:0] value_mem  [WINDOW];
  logic [31:0] ballot_mem [WINDOW];
  logic [7:0]  voter_mem  [WINDOW];
  logic [WINDOW-1:0] filled_q;

  logic [1:0]  op_q;
  logic [31:0] slot_q, val_q, ballot_q;
  logic [7:0]  mask_q;
  logic [2:0]  voter_q;
  logic [31:0] start_q, end_q, free_q, scan_q;
  logic [IdxW-1:0] start_idx_q, scan_idx_q;
  logic [StW-1:0] steps_q;
  logic        acc_q;
  logic [31:0] found_q;
  logic        ovalid_q;

  // ring entry of a slot given its offset from the window start
  function automatic logic [IdxW-1:0] idx_add(input logic [IdxW-1:0] base,
                                              input logic [IdxW:0] off);
    logic [SumW-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= SumW'(WINDOW)) sum = sum - SumW'(WINDOW);
    return sum[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    return (i == IdxW'(WINDOW - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [IdxW-1:0] idx, hidx, fidx, sidx;
  logic            inwin, fill_i, merge, ins_ok, vote_ok;
  logic [31:0]     sdiff, fdiff, sdepth;
  logic [PcW-1:0]  pc;

  always_comb begin
    sdiff   = slot_q - start_q;
    fdiff   = free_q - start_q;
    sdepth  = scan_q - start_q;
    idx     = idx_add(start_idx_q, sdiff[IdxW:0]);
    hidx    = start_idx_q;
    fidx    = idx_add(start_idx_q, fdiff[IdxW:0]);
    sidx    = scan_idx_q;
    inwin   = sdiff < 32'(WINDOW);
    fill_i  = filled_q[idx];
    ins_ok  = inwin && !(fill_i && ballot_q < ballot_mem[idx]);
    merge   = fill_i && value_mem[idx] == val_q && ballot_mem[idx] == ballot_q;
    vote_ok = inwin && fill_i && (32'(voter_q) < 32'(NODES));
    pc      = '0;
    for (int b = 0; b < 8; b++) pc = pc + PcW'(voter_mem[sidx][b]);
    stat_o.is_find    = op_q == OP_FIND;
    stat_o.find_more  = (steps_q < StW'(WINDOW)) && (fdiff < 32'(WINDOW)) && filled_q[fidx];
    stat_o.scan_more  = filled_q[sidx] && ({pc, 1'b0} > {1'b0, num_nodes_i}) &&
                        (sdepth < 32'(ScanMax));
    stat_o.conf_left  = sdepth != 32'd0;
    stat_o.conf_last  = sdepth == 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      slot_q   <= slot_number_i;
      val_q    <= entry_value_i;
      mask_q   <= vote_mask_i & NodeMask;
      ballot_q <= ballot_number_i;
      voter_q  <= voter_id_i;
    end
    if (cmd_i.exec && op_q == OP_INSERT && ins_ok) begin
      if (merge) voter_mem[idx] <= voter_mem[idx] | mask_q;
      else begin
        value_mem[idx]  <= val_q;
        ballot_mem[idx] <= ballot_q;
        voter_mem[idx]  <= mask_q;
      end
    end
    if (cmd_i.exec && op_q == OP_VOTE && vote_ok)
      voter_mem[idx] <= voter_mem[idx] | (8'd1 << voter_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      start_q  <= '0;
      end_q    <= '0;
      free_q   <= '0;
      scan_q   <= '0;
      start_idx_q <= '0;
      scan_idx_q  <= '0;
      steps_q  <= '0;
      acc_q    <= 1'b0;
      found_q  <= '0;
      ovalid_q <= 1'b0;
      confirmed_valid_o <= 1'b0;
      confirmed_slot_o  <= '0;
      confirmed_value_o <= '0;
      last_result_o     <= 1'b0;
      accepted_o        <= 1'b0;
      found_slot_o      <= '0;
      window_start_o    <= '0;
      highest_slot_o    <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (cmd_i.load) begin
        acc_q   <= 1'b0;
        found_q <= '0;
      end
      if (cmd_i.exec && op_q == OP_INSERT && ins_ok) begin
        filled_q[idx] <= 1'b1;
        acc_q         <= 1'b1;
        if (slot_q > end_q) end_q <= slot_q;
      end
      if (cmd_i.find_init) begin
        steps_q <= '0;
        acc_q   <= 1'b1;
        if (free_q < start_q) begin
          free_q  <= start_q;
          found_q <= start_q;
        end else found_q <= free_q;
      end
      if (cmd_i.find_step) begin
        free_q  <= free_q + 32'd1;
        found_q <= free_q + 32'd1;
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.scan_step) begin
        scan_q     <= scan_q + 32'd1;
        scan_idx_q <= idx_inc(scan_idx_q);
      end
      if (cmd_i.confirm) begin
        filled_q[hidx] <= 1'b0;
        start_q        <= start_q + 32'd1;
        start_idx_q    <= idx_inc(start_idx_q);
      end
      if (cmd_i.confirm || cmd_i.emit_last) begin
        ovalid_q          <= 1'b1;
        accepted_o        <= acc_q;
        found_slot_o      <= found_q;
        // scan pointer already sits past every slot this input confirms
        window_start_o    <= scan_q;
        highest_slot_o    <= end_q;
        confirmed_valid_o <= cmd_i.confirm;
        confirmed_slot_o  <= cmd_i.confirm ? start_q : '0;
        confirmed_value_o <= cmd_i.confirm ? value_mem[hidx] : '0;
        last_result_o     <= cmd_i.emit_last || stat_o.conf_last;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_busy_o  = ovalid_q;

endmodule
